// ===== design/amdfs_pkg.sv =====
// ----------------------------------------------------------------------------
// amdfs_pkg
// Shared constants for the adjacency-matrix depth-first search engine:
// field widths, command codes, status codes and parameter defaults.
// ----------------------------------------------------------------------------
package amdfs_pkg;

   // Field widths of the command and response beats
   localparam int OP_W     = 3;
   localparam int VIDX_W   = 4;
   localparam int ELEM_W   = 8;
   localparam int STATUS_W = 2;
   localparam int EDGES_W  = 8;
   localparam int VCOUNT_W = 5;

   // Result cap: one 4-bit vertex index space
   localparam int RESULT_CAP = 16;

   // Parameter defaults
   localparam int MAX_VERTICES_DEFAULT = 16;
   localparam int ELEM_BITS_DEFAULT    = 8;

   // Reset value of the vertex count register
   localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd16;

   // Command codes
   localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
   localparam logic [OP_W-1:0] OP_SET    = 3'd2;
   localparam logic [OP_W-1:0] OP_GET    = 3'd3;
   localparam logic [OP_W-1:0] OP_WALK   = 3'd4;

   // Status codes
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_SELF  = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd3;

endpackage

// ===== design/adjacency_matrix_dfs_engine_unit.sv =====
// ----------------------------------------------------------------------------
// adjacency_matrix_dfs_engine_unit
// Directed graph held as an adjacency bit matrix with one element per vertex;
// edge edits, element set/get and a depth-first walk driven by one sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the req_ channel (valid/ready), results leave on the
//   rsp_ channel (valid/ready). The csr_ port writes the vertex count; the
//   user writes it only while the engine is idle (the block does not
//   enforce this), and it takes effect on the next command. Edge, set and
//   get commands give one result beat, loaded in the execute state once the
//   result register is free; req_ready returns when the sequencer is idle
//   again, so a new command is taken only after that beat is loaded. A
//   traversal gives one beat per vertex in use, in preorder, with rsp_last on
//   the final beat; with zero vertices in use it gives a single status beat.
//   The walk sequencer runs one find-first-set each cycle over a row of the
//   matrix masked by the visited marks (over all unvisited vertices in use
//   when the stack is empty), and either pushes one vertex (one beat) or
//   pops the stack. A walk over n vertices takes the execute state, n
//   pushes and at most n - 1 pops. req_ready is high only between commands;
//   one command is in flight. A stalled receiver holds the result register;
//   the walk waits on a push until the beat is taken, pops continue meanwhile.
//   Reset clears the matrix, edge count, stack depth and visited marks and
//   sets the vertex count to 16; vertex elements are not cleared.
// ----------------------------------------------------------------------------
module adjacency_matrix_dfs_engine_unit #(
   parameter int MAX_VERTICES = amdfs_pkg::MAX_VERTICES_DEFAULT,
   parameter int ELEM_BITS    = amdfs_pkg::ELEM_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // command channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [amdfs_pkg::OP_W-1:0]          req_op,
   input  logic [amdfs_pkg::VIDX_W-1:0]        req_src_vertex,
   input  logic [amdfs_pkg::VIDX_W-1:0]        req_dst_vertex,
   input  logic [amdfs_pkg::ELEM_W-1:0]        req_element_in,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [amdfs_pkg::STATUS_W-1:0]      rsp_status,
   output logic [amdfs_pkg::VIDX_W-1:0]        rsp_vertex_index,
   output logic [amdfs_pkg::ELEM_W-1:0]        rsp_element_out,
   output logic [amdfs_pkg::EDGES_W-1:0]       rsp_edge_total,
   output logic                                rsp_last,
   // configuration
   input  logic                                csr_wr_en,
   input  logic [amdfs_pkg::VCOUNT_W-1:0]      csr_wr_data
);

   // Vertices actually addressable: capped by the 4-bit index space
   localparam int NV      = (MAX_VERTICES < amdfs_pkg::RESULT_CAP) ?
                            MAX_VERTICES : amdfs_pkg::RESULT_CAP;
   localparam int VW      = $clog2(NV);
   localparam int EXT_W   = (ELEM_BITS > amdfs_pkg::ELEM_W) ? ELEM_BITS : amdfs_pkg::ELEM_W;
   localparam int VCW     = amdfs_pkg::VCOUNT_W;

   // Sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_WALK = 2'd2;

   // Control registers
   logic [1:0]                          state_ff, state_in;
   logic [VCW-1:0]                      vcount_ff;
   logic [VW:0]                         sp_ff, sp_in;
   logic [VW:0]                         k_ff, k_in;
   logic [NV-1:0]                       visited_ff, visited_in;
   logic [amdfs_pkg::EDGES_W-1:0]       edge_cnt_ff, edge_cnt_in;
   logic                                rsp_valid_ff;

   // Latched command
   logic [amdfs_pkg::OP_W-1:0]          cmd_op_ff;
   logic [amdfs_pkg::VIDX_W-1:0]        cmd_src_ff;
   logic [amdfs_pkg::VIDX_W-1:0]        cmd_dst_ff;
   logic [amdfs_pkg::ELEM_W-1:0]        cmd_elem_ff;

   // Result register payload
   logic [amdfs_pkg::STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [amdfs_pkg::VIDX_W-1:0]        rsp_vertex_ff, rsp_vertex_in;
   logic [amdfs_pkg::ELEM_W-1:0]        rsp_elem_ff, rsp_elem_in;
   logic [amdfs_pkg::EDGES_W-1:0]       rsp_edges_ff;
   logic                                rsp_last_ff, rsp_last_in;
   logic                                rsp_load;

   // Storage
   logic [NV-1:0]                       adjacency_ff [NV];
   logic [ELEM_BITS-1:0]                elements_ff  [NV];
   logic [VW-1:0]                       stack_ff     [NV];

   // Storage write ports
   logic                                adj_we;
   logic [NV-1:0]                       adj_wdata;
   logic                                elem_we;
   logic [ELEM_BITS-1:0]                elem_wdata;
   logic                                stack_we;

   // Read side
   logic [VW-1:0]                       top_vertex;
   logic [VW-1:0]                       adj_addr;
   logic [NV-1:0]                       adj_row;
   logic [VW-1:0]                       elem_addr;
   logic [EXT_W-1:0]                    elem_rd_wide;
   logic [EXT_W-1:0]                    elem_wr_wide;
   logic [EXT_W-1:0]                    elem_echo_wide;

   // Find-first unit and helpers
   logic [VCW-1:0]                      n_eff;
   logic [NV-1:0]                       active_mask;
   logic [NV-1:0]                       ff_vec;
   logic [VW-1:0]                       ff_idx;
   logic                                ff_found;
   logic                                out_free;
   logic                                src_bad;
   logic                                dst_bad;
   logic                                edge_bit;

   // Vertex count in use and its mask
   assign n_eff = (vcount_ff > VCW'(NV)) ? VCW'(NV) : vcount_ff;

   always_comb begin
      for (int i = 0; i < NV; i++) begin
         active_mask[i] = (VCW'(i) < n_eff);
      end
   end

   assign src_bad  = ({1'b0, cmd_src_ff} >= n_eff);
   assign dst_bad  = ({1'b0, cmd_dst_ff} >= n_eff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Stack top and shared row read
   assign top_vertex = stack_ff[VW'(sp_ff - 1'b1)];
   assign adj_addr   = (state_ff == S_WALK) ? top_vertex : cmd_src_ff[VW-1:0];
   assign adj_row    = adjacency_ff[adj_addr];
   assign edge_bit   = adj_row[cmd_dst_ff[VW-1:0]];

   // Shared find-first unit: neighbor search, or next start when stack empty
   assign ff_vec = (sp_ff == '0) ? (active_mask & ~visited_ff)
                                 : (adj_row & active_mask & ~visited_ff);

   always_comb begin
      ff_idx = '0;
      for (int i = NV - 1; i >= 0; i--) begin
         if (ff_vec[i]) begin
            ff_idx = VW'(i);
         end
      end
   end

   assign ff_found = |ff_vec;

   // Element read and write, widened to the port width
   assign elem_addr      = (state_ff == S_WALK) ? ff_idx : cmd_src_ff[VW-1:0];
   assign elem_rd_wide   = EXT_W'(elements_ff[elem_addr]);
   assign elem_wr_wide   = EXT_W'(cmd_elem_ff);
   assign elem_wdata     = elem_wr_wide[ELEM_BITS-1:0];
   // set echoes the value as stored, cut to the element width
   assign elem_echo_wide = EXT_W'(elem_wdata);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      sp_in         = sp_ff;
      k_in          = k_ff;
      visited_in    = visited_ff;
      edge_cnt_in   = edge_cnt_ff;
      rsp_load      = 1'b0;
      rsp_status_in = amdfs_pkg::STAT_OK;
      rsp_vertex_in = cmd_src_ff;
      rsp_elem_in   = '0;
      rsp_last_in   = 1'b1;
      adj_we        = 1'b0;
      adj_wdata     = adj_row;
      elem_we       = 1'b0;
      stack_we      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            unique case (cmd_op_ff) inside
               amdfs_pkg::OP_INSERT, amdfs_pkg::OP_DELETE: begin
                  if (out_free) begin
                     rsp_load = 1'b1;
                     state_in = S_IDLE;
                     if (src_bad || dst_bad) begin
                        rsp_status_in = amdfs_pkg::STAT_RANGE;
                     end else if (cmd_src_ff == cmd_dst_ff) begin
                        rsp_status_in = amdfs_pkg::STAT_SELF;
                     end else if (cmd_op_ff == amdfs_pkg::OP_INSERT) begin
                        // count only a real change
                        if (!edge_bit) begin
                           adj_we      = 1'b1;
                           adj_wdata   = adj_row | (NV'(1) << cmd_dst_ff[VW-1:0]);
                           edge_cnt_in = edge_cnt_ff + 1'b1;
                        end
                     end else begin
                        if (edge_bit) begin
                           adj_we      = 1'b1;
                           adj_wdata   = adj_row & ~(NV'(1) << cmd_dst_ff[VW-1:0]);
                           edge_cnt_in = edge_cnt_ff - 1'b1;
                        end
                     end
                  end
               end

               amdfs_pkg::OP_SET, amdfs_pkg::OP_GET: begin
                  if (out_free) begin
                     rsp_load = 1'b1;
                     state_in = S_IDLE;
                     if (src_bad) begin
                        rsp_status_in = amdfs_pkg::STAT_RANGE;
                     end else if (cmd_op_ff == amdfs_pkg::OP_SET) begin
                        elem_we     = 1'b1;
                        rsp_elem_in = elem_echo_wide[amdfs_pkg::ELEM_W-1:0];
                     end else begin
                        rsp_elem_in = elem_rd_wide[amdfs_pkg::ELEM_W-1:0];
                     end
                  end
               end

               amdfs_pkg::OP_WALK: begin
                  if (n_eff == '0) begin
                     if (out_free) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = amdfs_pkg::STAT_EMPTY;
                        rsp_vertex_in = '0;
                        state_in      = S_IDLE;
                     end
                  end else begin
                     visited_in = '0;
                     sp_in      = '0;
                     k_in       = '0;
                     state_in   = S_WALK;
                  end
               end

               default: begin
                  // unknown command: no result
                  state_in = S_IDLE;
               end
            endcase
         end

         S_WALK: begin
            if (ff_found) begin
               // push: visit, emit beat, stack it
               if (out_free) begin
                  rsp_load      = 1'b1;
                  rsp_vertex_in = amdfs_pkg::VIDX_W'(ff_idx);
                  rsp_elem_in   = elem_rd_wide[amdfs_pkg::ELEM_W-1:0];
                  rsp_last_in   = (VCW'(k_ff) + 1'b1 == n_eff);
                  visited_in    = visited_ff | (NV'(1) << ff_idx);
                  stack_we      = 1'b1;
                  sp_in         = sp_ff + 1'b1;
                  k_in          = k_ff + 1'b1;
                  if (rsp_last_in) begin
                     state_in = S_IDLE;
                  end
               end
            end else begin
               // no unvisited neighbor: pop
               sp_in = sp_ff - 1'b1;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vcount_ff    <= amdfs_pkg::VCOUNT_RESET;
         sp_ff        <= '0;
         k_ff         <= '0;
         visited_ff   <= '0;
         edge_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         sp_ff       <= sp_in;
         k_ff        <= k_in;
         visited_ff  <= visited_in;
         edge_cnt_ff <= edge_cnt_in;
         if (csr_wr_en) begin
            vcount_ff <= csr_wr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Command capture
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_op_ff   <= req_op;
         cmd_src_ff  <= req_src_vertex;
         cmd_dst_ff  <= req_dst_vertex;
         cmd_elem_ff <= req_element_in;
      end
   end

   // Result register payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_vertex_ff <= rsp_vertex_in;
         rsp_elem_ff   <= rsp_elem_in;
         rsp_edges_ff  <= edge_cnt_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   // Adjacency matrix, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NV; i++) begin
            adjacency_ff[i] <= '0;
         end
      end else if (adj_we) begin
         adjacency_ff[cmd_src_ff[VW-1:0]] <= adj_wdata;
      end
   end

   // Vertex elements, undefined until written
   always_ff @(posedge clock) begin
      if (elem_we) begin
         elements_ff[cmd_src_ff[VW-1:0]] <= elem_wdata;
      end
   end

   // Walk stack
   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_ff[sp_ff[VW-1:0]] <= ff_idx;
      end
   end

   // Ports
   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_vertex_index = rsp_vertex_ff;
   assign rsp_element_out  = rsp_elem_ff;
   assign rsp_edge_total   = rsp_edges_ff;
   assign rsp_last         = rsp_last_ff;

   // Assertions
   // every beat of a walk marks exactly one vertex
   a_visit_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> ($countones(visited_ff) == int'(k_ff)))
      else $error("visited marks disagree with beats emitted");

   // stack never deeper than the beats emitted
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (sp_ff <= k_ff))
      else $error("walk stack deeper than visited count");

   // final walk beat ends the command
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_last_in) |=> (state_ff == S_IDLE))
      else $error("sequencer busy after final beat");

   // edge count moves by at most one per cycle, and only on an edit
   a_edge_step: assert property (@(posedge clock) disable iff (reset)
      (edge_cnt_ff != $past(edge_cnt_ff)) |->
         ($past(adj_we) && ((edge_cnt_ff == $past(edge_cnt_ff) + 8'd1) ||
                            (edge_cnt_ff == $past(edge_cnt_ff) - 8'd1))))
      else $error("edge count changed without a matrix edit");

endmodule
